/* src/common_neighbor_finder_assert.svh */
// assertion helpers for the common neighbor finder
`ifndef COMMON_NEIGHBOR_FINDER_ASSERT_SVH
`define COMMON_NEIGHBOR_FINDER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define CNF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("common_neighbor_finder check failed");

// antecedent implies consequent in the next cycle
`define CNF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("common_neighbor_finder check failed");

`endif

/* src/cnf_pkg.sv */
`default_nettype none
package cnf_pkg;

  localparam int unsigned NODE_IDX_W     = 4;
  localparam int unsigned NODE_VALS      = 2 ** NODE_IDX_W;
  localparam int unsigned CFG_W          = 5;
  localparam int unsigned STATUS_W       = 2;
  localparam int unsigned MAX_NODES_DEF  = 16;
  localparam int unsigned MAX_DEGREE_DEF = 16;

  localparam logic [CFG_W-1:0] NODE_COUNT_RST = CFG_W'(16);

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OOR  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic                  command;
    logic [NODE_IDX_W-1:0] node_a;
    logic [NODE_IDX_W-1:0] node_b;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [NODE_IDX_W-1:0] neighbor;
    logic                  found;
    logic                  last;
  } out_item_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage
`default_nettype wire

/* src/cnf_nbr_mem.sv */
`default_nettype none
module cnf_nbr_mem #(
  parameter int unsigned MAX_NODES  = cnf_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_DEGREE = cnf_pkg::MAX_DEGREE_DEF,
  localparam int unsigned DEPTH  = MAX_NODES * MAX_DEGREE,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire                                clk_i,
  input  wire cnf_pkg::mem_ctl_t             ctl_i,
  input  wire logic [ADDR_W-1:0]             waddr_i,
  input  wire logic [cnf_pkg::NODE_IDX_W-1:0] wdata_i,
  input  wire logic [ADDR_W-1:0]             raddr_i,
  output logic [cnf_pkg::NODE_IDX_W-1:0]     rdata_o
);
  import cnf_pkg::*;

  logic [NODE_IDX_W-1:0] mem_q [DEPTH];
  logic [NODE_IDX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* src/cnf_deg_mem.sv */
`default_nettype none
module cnf_deg_mem #(
  parameter int unsigned MAX_NODES  = cnf_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_DEGREE = cnf_pkg::MAX_DEGREE_DEF,
  localparam int unsigned NODE_W = $clog2(MAX_NODES),
  localparam int unsigned CNT_W  = $clog2(MAX_DEGREE + 1)
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire cnf_pkg::mem_ctl_t ctl_i,
  input  wire logic [NODE_W-1:0] waddr_i,
  input  wire logic [CNT_W-1:0]  wdata_i,
  input  wire logic [NODE_W-1:0] raddr_i,
  output logic [CNT_W-1:0]       rdata_o
);
  import cnf_pkg::*;

  logic [CNT_W-1:0]     mem_q [MAX_NODES];
  logic [MAX_NODES-1:0] valid_q;
  logic [CNT_W-1:0]     rdata_q;

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctl_i.we) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_q <= valid_q[raddr_i] ? mem_q[raddr_i] : '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* src/cnf_seq.sv */
`default_nettype none
module cnf_seq #(
  parameter int unsigned MAX_NODES  = cnf_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_DEGREE = cnf_pkg::MAX_DEGREE_DEF,
  localparam int unsigned NODE_W = $clog2(MAX_NODES),
  localparam int unsigned CNT_W  = $clog2(MAX_DEGREE + 1),
  localparam int unsigned ADDR_W = $clog2(MAX_NODES * MAX_DEGREE)
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire logic [cnf_pkg::CFG_W-1:0]      node_count_i,
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  wire cnf_pkg::in_item_t              in_item_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output cnf_pkg::out_item_t                  out_item_o,
  output cnf_pkg::mem_ctl_t                   nbr_ctl_o,
  output logic [ADDR_W-1:0]                   nbr_waddr_o,
  output logic [cnf_pkg::NODE_IDX_W-1:0]      nbr_wdata_o,
  output logic [ADDR_W-1:0]                   nbr_raddr_o,
  input  wire logic [cnf_pkg::NODE_IDX_W-1:0] nbr_rdata_i,
  output cnf_pkg::mem_ctl_t                   deg_ctl_o,
  output logic [NODE_W-1:0]                   deg_waddr_o,
  output logic [CNT_W-1:0]                    deg_wdata_o,
  output logic [NODE_W-1:0]                   deg_raddr_o,
  input  wire logic [CNT_W-1:0]               deg_rdata_i
);
  import cnf_pkg::*;

  localparam int unsigned LIM_W =
    ($clog2(MAX_NODES + 1) > CFG_W) ? $clog2(MAX_NODES + 1) : CFG_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_DEGA  = 4'd2;
  localparam logic [3:0] S_DEGB  = 4'd3;
  localparam logic [3:0] S_ADDA  = 4'd4;
  localparam logic [3:0] S_ADDB  = 4'd5;
  localparam logic [3:0] S_SCANB = 4'd6;
  localparam logic [3:0] S_SCANA = 4'd7;
  localparam logic [3:0] S_FINAL = 4'd8;

  function automatic logic [ADDR_W-1:0] slot_addr(
    input logic [NODE_IDX_W-1:0] node,
    input logic [CNT_W-1:0]      idx
  );
    slot_addr = ADDR_W'(ADDR_W'(node) * ADDR_W'(MAX_DEGREE)) + ADDR_W'(idx);
  endfunction

  logic [3:0]           state_q, state_d;
  in_item_t             item_q, item_d;
  logic [CNT_W-1:0]     deg_a_q, deg_a_d;
  logic [CNT_W-1:0]     deg_b_q, deg_b_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic                 pend_q, pend_d;
  logic [NODE_VALS-1:0] mask_q, mask_d;
  logic [NODE_IDX_W-1:0] hold_q, hold_d;
  logic                 hold_vld_q, hold_vld_d;
  logic [STATUS_W-1:0]  fin_q, fin_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q, out_d;

  logic                 can_load;
  logic                 oor;
  logic                 self_loop;
  logic                 room;
  logic [CNT_W-1:0]     deg_b_eff;
  logic                 hit;
  logic                 stall;

  assign can_load  = !out_valid_q || out_ready_i;
  assign oor       = (LIM_W'(item_q.node_a) >= LIM_W'(node_count_i))
                  || (LIM_W'(item_q.node_b) >= LIM_W'(node_count_i))
                  || (LIM_W'(item_q.node_a) >= LIM_W'(MAX_NODES))
                  || (LIM_W'(item_q.node_b) >= LIM_W'(MAX_NODES));
  assign self_loop = item_q.node_a == item_q.node_b;
  assign room      = self_loop
      ? ((CNT_W + 1)'(deg_a_q) + (CNT_W + 1)'(2) <= (CNT_W + 1)'(MAX_DEGREE))
      : ((deg_a_q < CNT_W'(MAX_DEGREE)) && (deg_b_q < CNT_W'(MAX_DEGREE)));
  assign deg_b_eff = self_loop ? CNT_W'(deg_a_q + 1'b1) : deg_b_q;
  assign hit       = pend_q && mask_q[nbr_rdata_i];
  assign stall     = hit && hold_vld_q && !can_load;

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    deg_a_d     = deg_a_q;
    deg_b_d     = deg_b_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    mask_d      = mask_q;
    hold_d      = hold_q;
    hold_vld_d  = hold_vld_q;
    fin_d       = fin_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    in_ready_o  = 1'b0;
    nbr_ctl_o   = '0;
    nbr_waddr_o = slot_addr(item_q.node_a, deg_a_q);
    nbr_wdata_o = item_q.node_b;
    nbr_raddr_o = slot_addr(item_q.node_b, idx_q);
    deg_ctl_o   = '0;
    deg_waddr_o = NODE_W'(item_q.node_a);
    deg_wdata_o = CNT_W'(deg_a_q + 1'b1);
    deg_raddr_o = NODE_W'(item_q.node_a);

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d     = in_item_i;
          mask_d     = '0;
          hold_vld_d = 1'b0;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (oor) begin
          fin_d   = STATUS_OOR;
          state_d = S_FINAL;
        end else begin
          deg_ctl_o.re = 1'b1;
          state_d      = S_DEGA;
        end
      end
      S_DEGA: begin
        deg_a_d      = deg_rdata_i;
        deg_ctl_o.re = 1'b1;
        deg_raddr_o  = NODE_W'(item_q.node_b);
        state_d      = S_DEGB;
      end
      S_DEGB: begin
        deg_b_d = deg_rdata_i;
        idx_d   = '0;
        pend_d  = 1'b0;
        fin_d   = STATUS_OK;
        state_d = (item_q.command == CMD_ADD) ? S_ADDA : S_SCANB;
      end
      S_ADDA: begin
        if (!room) begin
          fin_d   = STATUS_FULL;
          state_d = S_FINAL;
        end else begin
          nbr_ctl_o.we = 1'b1;
          deg_ctl_o.we = 1'b1;
          state_d      = S_ADDB;
        end
      end
      S_ADDB: begin
        nbr_ctl_o.we = 1'b1;
        nbr_waddr_o  = slot_addr(item_q.node_b, deg_b_eff);
        nbr_wdata_o  = item_q.node_a;
        deg_ctl_o.we = 1'b1;
        deg_waddr_o  = NODE_W'(item_q.node_b);
        deg_wdata_o  = CNT_W'(deg_b_eff + 1'b1);
        state_d      = S_FINAL;
      end
      S_SCANB: begin
        // build a presence mask of the second list
        if (pend_q) begin
          mask_d[nbr_rdata_i] = 1'b1;
        end
        if (idx_q < deg_b_q) begin
          nbr_ctl_o.re = 1'b1;
          idx_d        = CNT_W'(idx_q + 1'b1);
          pend_d       = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            idx_d   = '0;
            state_d = S_SCANA;
          end
        end
      end
      S_SCANA: begin
        nbr_raddr_o = slot_addr(item_q.node_a, idx_q);
        if (!stall) begin
          if (idx_q < deg_a_q) begin
            nbr_ctl_o.re = 1'b1;
            idx_d        = CNT_W'(idx_q + 1'b1);
            pend_d       = 1'b1;
          end else begin
            pend_d = 1'b0;
            if (!pend_q) begin
              state_d = S_FINAL;
            end
          end
          // one hit is held back so the final one can carry last
          if (hit) begin
            if (hold_vld_q) begin
              out_valid_d = 1'b1;
              out_d       = '{status: STATUS_OK, neighbor: hold_q, found: 1'b1,
                              last: 1'b0};
            end
            hold_d     = nbr_rdata_i;
            hold_vld_d = 1'b1;
          end
        end
      end
      S_FINAL: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          if (hold_vld_q) begin
            out_d = '{status: STATUS_OK, neighbor: hold_q, found: 1'b1, last: 1'b1};
          end else begin
            out_d = '{status: fin_q, neighbor: '0, found: 1'b0, last: 1'b1};
          end
          hold_vld_d = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= 1'b0;
      hold_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      hold_vld_q  <= hold_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    deg_a_q <= deg_a_d;
    deg_b_q <= deg_b_d;
    idx_q   <= idx_d;
    mask_q  <= mask_d;
    hold_q  <= hold_d;
    fin_q   <= fin_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
`default_nettype wire

/* src/common_neighbor_finder.sv */
`default_nettype none
// Common neighbor finder: holds an undirected graph as per-node neighbor lists in a
// neighbor memory with one write port and one read port plus a degree table, driven
// by one small sequencer that handles one transaction at a time (in_ready_o is low
// while it works). An add-edge transaction runs a range check, two degree reads, two
// list appends and the result; one dropped because a list is full skips the appends.
// A query reads the second node's list one entry per cycle into a presence mask, then
// reads the first node's list one entry per cycle, unless a result stalls it, and
// checks each entry against the mask; every entry of the first list found in the mask
// is one result, the final one marked last, or else there is a single not-found
// result. An out-of-range transaction goes from the range check straight to the
// result. The memory read port sets the per-entry pace; results stall the scan, and
// the final result waits, only while the output register is still full.
module common_neighbor_finder #(
  parameter int unsigned MAX_NODES  = cnf_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_DEGREE = cnf_pkg::MAX_DEGREE_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [cnf_pkg::CFG_W-1:0] cfg_data_i,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire cnf_pkg::in_item_t         in_item_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output cnf_pkg::out_item_t             out_item_o
);
  import cnf_pkg::*;

  localparam int unsigned NODE_W = $clog2(MAX_NODES);
  localparam int unsigned CNT_W  = $clog2(MAX_DEGREE + 1);
  localparam int unsigned ADDR_W = $clog2(MAX_NODES * MAX_DEGREE);

  logic [CFG_W-1:0]      node_count_q;
  mem_ctl_t              nbr_ctl;
  logic [ADDR_W-1:0]     nbr_waddr;
  logic [NODE_IDX_W-1:0] nbr_wdata;
  logic [ADDR_W-1:0]     nbr_raddr;
  logic [NODE_IDX_W-1:0] nbr_rdata;
  mem_ctl_t              deg_ctl;
  logic [NODE_W-1:0]     deg_waddr;
  logic [CNT_W-1:0]      deg_wdata;
  logic [NODE_W-1:0]     deg_raddr;
  logic [CNT_W-1:0]      deg_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
    end else if (cfg_valid_i) begin
      node_count_q <= cfg_data_i;
    end
  end

  cnf_seq #(
    .MAX_NODES (MAX_NODES),
    .MAX_DEGREE(MAX_DEGREE)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .node_count_i(node_count_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .nbr_ctl_o   (nbr_ctl),
    .nbr_waddr_o (nbr_waddr),
    .nbr_wdata_o (nbr_wdata),
    .nbr_raddr_o (nbr_raddr),
    .nbr_rdata_i (nbr_rdata),
    .deg_ctl_o   (deg_ctl),
    .deg_waddr_o (deg_waddr),
    .deg_wdata_o (deg_wdata),
    .deg_raddr_o (deg_raddr),
    .deg_rdata_i (deg_rdata)
  );

  cnf_nbr_mem #(
    .MAX_NODES (MAX_NODES),
    .MAX_DEGREE(MAX_DEGREE)
  ) u_nbr_mem (
    .clk_i  (clk_i),
    .ctl_i  (nbr_ctl),
    .waddr_i(nbr_waddr),
    .wdata_i(nbr_wdata),
    .raddr_i(nbr_raddr),
    .rdata_o(nbr_rdata)
  );

  cnf_deg_mem #(
    .MAX_NODES (MAX_NODES),
    .MAX_DEGREE(MAX_DEGREE)
  ) u_deg_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (deg_ctl),
    .waddr_i(deg_waddr),
    .wdata_i(deg_wdata),
    .raddr_i(deg_raddr),
    .rdata_o(deg_rdata)
  );

`include "common_neighbor_finder_assert.svh"

  `CNF_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `CNF_ASSERT_NOW(a_notfound_zero, clk_i, rst_ni, out_valid_o && !out_item_o.found, out_item_o.neighbor == '0)
  `CNF_ASSERT_NOW(a_error_is_last, clk_i, rst_ni, out_valid_o && out_item_o.status != STATUS_OK, out_item_o.last && !out_item_o.found)
  `CNF_ASSERT_NOW(a_no_two_writes, clk_i, rst_ni, nbr_ctl.we, !nbr_ctl.re)

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
module tb;
  import cnf_pkg::*;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    logic [4:0] cfg_val;
    in_item_t   item;
    bit         typed;
    out_item_t  want;
  } plan_row_t;

  localparam out_item_t RES_DONE = '{STATUS_OK, 4'd0, 1'b0, 1'b1};
  localparam out_item_t RES_OOR  = '{STATUS_OOR, 4'd0, 1'b0, 1'b1};
  localparam out_item_t RES_FULL = '{STATUS_FULL, 4'd0, 1'b0, 1'b1};

  localparam int PLAN_LEN = 31;
  localparam plan_row_t DIRECTED_PLAN [PLAN_LEN] = '{
    '{ROW_ITEM, 5'd0, '{CMD_QUERY, 4'd0, 4'd0}, 1'b1, RES_DONE},
    '{ROW_ITEM, 5'd0, '{CMD_ADD, 4'd0, 4'd15}, 1'b1, RES_DONE},
    '{ROW_ITEM, 5'd0, '{CMD_ADD, 4'd15, 4'd15}, 1'b0, RES_DONE},
    '{ROW_ITEM, 5'd0, '{CMD_ADD, 4'd0, 4'd0}, 1'b0, RES_DONE},
    '{ROW_ITEM, 5'd0, '{CMD_ADD, 4'd3, 4'd0}, 1'b0, RES_DONE},
    '{ROW_ITEM, 5'd0, '{CMD_ADD, 4'd3, 4'd15}, 1'b0, RES_DONE},
    '{ROW_ITEM, 5'd0, '{CMD_QUERY, 4'd0, 4'd15}, 1'b0, RES_DONE},
    '{ROW_ITEM, 5'd0, '{CMD_QUERY, 4'd15, 4'd0}, 1'b0, RES_DONE},
    '{ROW_ITEM, 5'd0, '{CMD_QUERY, 4'd3, 4'd3}, 1'b0, RES_DONE},
    '{ROW_ITEM, 5'd0, '{CMD_ADD, 4'd9, 4'd9}, 1'b0, RES_DONE},
    '{ROW_ITEM, 5'd0, '{CMD_ADD, 4'd9, 4'd9}, 1'b0, RES_DONE},
    '{ROW_ITEM, 5'd0, '{CMD_ADD, 4'd9, 4'd9}, 1'b0, RES_DONE},
    '{ROW_ITEM, 5'd0, '{CMD_ADD, 4'd9, 4'd9}, 1'b0, RES_DONE},
    '{ROW_ITEM, 5'd0, '{CMD_ADD, 4'd9, 4'd9}, 1'b0, RES_DONE},
    '{ROW_ITEM, 5'd0, '{CMD_ADD, 4'd9, 4'd9}, 1'b0, RES_DONE},
    '{ROW_ITEM, 5'd0, '{CMD_ADD, 4'd9, 4'd9}, 1'b0, RES_DONE},
    '{ROW_ITEM, 5'd0, '{CMD_ADD, 4'd9, 4'd9}, 1'b0, RES_DONE},
    '{ROW_ITEM, 5'd0, '{CMD_ADD, 4'd9, 4'd9}, 1'b1, RES_FULL},
    '{ROW_ITEM, 5'd0, '{CMD_ADD, 4'd9, 4'd1}, 1'b1, RES_FULL},
    '{ROW_ITEM, 5'd0, '{CMD_ADD, 4'd1, 4'd9}, 1'b1, RES_FULL},
    '{ROW_ITEM, 5'd0, '{CMD_QUERY, 4'd9, 4'd9}, 1'b0, RES_DONE},
    '{ROW_CFG, 5'd1, '{CMD_ADD, 4'd0, 4'd0}, 1'b0, RES_DONE},
    '{ROW_ITEM, 5'd0, '{CMD_QUERY, 4'd0, 4'd0}, 1'b0, RES_DONE},
    '{ROW_ITEM, 5'd0, '{CMD_ADD, 4'd1, 4'd0}, 1'b1, RES_OOR},
    '{ROW_ITEM, 5'd0, '{CMD_QUERY, 4'd0, 4'd15}, 1'b1, RES_OOR},
    '{ROW_CFG, 5'd0, '{CMD_ADD, 4'd0, 4'd0}, 1'b0, RES_DONE},
    '{ROW_ITEM, 5'd0, '{CMD_QUERY, 4'd0, 4'd0}, 1'b1, RES_OOR},
    '{ROW_CFG, 5'd31, '{CMD_ADD, 4'd0, 4'd0}, 1'b0, RES_DONE},
    '{ROW_ITEM, 5'd0, '{CMD_ADD, 4'd15, 4'd14}, 1'b0, RES_DONE},
    '{ROW_ITEM, 5'd0, '{CMD_QUERY, 4'd14, 4'd15}, 1'b0, RES_DONE},
    '{ROW_CFG, 5'd16, '{CMD_ADD, 4'd0, 4'd0}, 1'b0, RES_DONE}
  };

  localparam int PHASES = 6;
  localparam logic [4:0] PHASE_NODE_COUNT [PHASES] = '{5'd16, 5'd2, 5'd31, 5'd1, 5'd7, 5'd16};
  localparam int ITEMS_PER_PHASE = 30;
  localparam int LONG_HOLD_AFTER = 60;
  localparam int LONG_HOLD_CYCLES = 400;

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  logic [CFG_W-1:0] node_count_m;
  logic [NODE_IDX_W-1:0] adj_m [MAX_NODES_DEF][MAX_DEGREE_DEF];
  int unsigned degree_m [MAX_NODES_DEF];
  out_item_t pending_results [$];

  bit        typed_row;
  out_item_t typed_want;
  int        accepted_items;
  int        error_count;
  int        burst_left;

  common_neighbor_finder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic void predict_graph_item(input in_item_t it, ref out_item_t res[$]);
    int unsigned lim;
    int unsigned da;
    int unsigned db;
    bit room;
    bit hit;
    logic [NODE_IDX_W-1:0] v;
    out_item_t r;
    out_item_t found_res;
    lim = (node_count_m > MAX_NODES_DEF) ? MAX_NODES_DEF : node_count_m;
    r = RES_DONE;
    if (it.node_a >= lim || it.node_b >= lim) begin
      r.status = STATUS_OOR;
      res.insert(res.size(), r);
      return;
    end
    da = degree_m[it.node_a];
    db = degree_m[it.node_b];
    if (it.command == CMD_ADD) begin
      room = (it.node_a == it.node_b) ? (da + 2 <= MAX_DEGREE_DEF)
                                      : (da < MAX_DEGREE_DEF && db < MAX_DEGREE_DEF);
      if (!room) begin
        r.status = STATUS_FULL;
      end else begin
        adj_m[it.node_a][degree_m[it.node_a]] = it.node_b;
        degree_m[it.node_a]++;
        adj_m[it.node_b][degree_m[it.node_b]] = it.node_a;
        degree_m[it.node_b]++;
      end
      res.insert(res.size(), r);
      return;
    end
    for (int i = 0; i < da; i++) begin
      v = adj_m[it.node_a][i];
      hit = 1'b0;
      for (int j = 0; j < db; j++) begin
        if (adj_m[it.node_b][j] == v) hit = 1'b1;
      end
      if (hit) begin
        found_res = '{STATUS_OK, v, 1'b1, 1'b0};
        res.insert(res.size(), found_res);
      end
    end
    if (res.size() == 0) res.insert(0, r);
    else res[res.size()-1].last = 1'b1;
  endfunction

  task automatic compare_field(input string name, input int want, input int got);
    if (want !== got) begin
      $error("%s expected %0d actual %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin : scoreboard
    out_item_t fresh [$];
    out_item_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) node_count_m = cfg_data_i;
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("unexpected transaction on output: %p", out_item_o);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          compare_field("status", want.status, out_item_o.status);
          compare_field("neighbor", want.neighbor, out_item_o.neighbor);
          compare_field("found", want.found, out_item_o.found);
          compare_field("last", want.last, out_item_o.last);
        end
      end
      if (in_valid_i && in_ready_o) begin
        fresh.delete();
        predict_graph_item(in_item_i, fresh);
        if (typed_row) pending_results.insert(pending_results.size(), typed_want);
        else foreach (fresh[k]) pending_results.insert(pending_results.size(), fresh[k]);
        accepted_items++;
      end
    end
  end

  // output side: stall pattern plus one long hold-off to back up the input
  initial begin : receiver
    int mode;
    int run_left;
    int hold_left;
    bit hold_done;
    out_ready_i = 1'b0;
    run_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    mode = 0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && accepted_items >= LONG_HOLD_AFTER) begin
        hold_left = LONG_HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else begin
        if (run_left == 0) begin
          mode = $urandom_range(0, 2);
          run_left = $urandom_range(8, 64);
        end
        run_left--;
        case (mode)
          0: out_ready_i = 1'b1;
          1: out_ready_i = $urandom_range(0, 1);
          default: out_ready_i = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic offer_item(input in_item_t it, input bit typed, input out_item_t want);
    int gap;
    if (burst_left == 0) begin
      in_valid_i = 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) @(negedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_item_i = it;
    typed_row = typed;
    typed_want = want;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_node_count(input logic [CFG_W-1:0] val);
    cfg_data_i = val;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin : stimulus
    in_item_t it;
    int unsigned eff;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    typed_row = 1'b0;
    typed_want = RES_DONE;
    accepted_items = 0;
    error_count = 0;
    burst_left = 0;
    node_count_m = NODE_COUNT_RST;
    foreach (degree_m[n]) degree_m[n] = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (DIRECTED_PLAN[k]) begin
      if (DIRECTED_PLAN[k].kind == ROW_CFG) begin
        drain_results();
        write_node_count(DIRECTED_PLAN[k].cfg_val);
      end else begin
        offer_item(DIRECTED_PLAN[k].item, DIRECTED_PLAN[k].typed, DIRECTED_PLAN[k].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      write_node_count(PHASE_NODE_COUNT[p]);
      eff = (PHASE_NODE_COUNT[p] > MAX_NODES_DEF) ? MAX_NODES_DEF : PHASE_NODE_COUNT[p];
      repeat (ITEMS_PER_PHASE) begin
        it.command = $urandom_range(0, 1) ? CMD_QUERY : CMD_ADD;
        if (eff != 0 && $urandom_range(0, 99) < 85) begin
          it.node_a = NODE_IDX_W'($urandom_range(0, eff - 1));
          it.node_b = NODE_IDX_W'($urandom_range(0, eff - 1));
        end else begin
          it.node_a = NODE_IDX_W'($urandom_range(0, NODE_VALS - 1));
          it.node_b = NODE_IDX_W'($urandom_range(0, NODE_VALS - 1));
        end
        offer_item(it, 1'b0, RES_DONE);
      end
    end

    drain_results();
    repeat (64) @(negedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/cnf_pkg.sv
src/cnf_nbr_mem.sv
src/cnf_deg_mem.sv
src/cnf_seq.sv
src/common_neighbor_finder.sv
tb/sv/tb.sv
